>>> rtl/sjfat_pkg.sv
package sjfat_pkg;

	// Capacity of the job store.
	localparam int MAX_JOBS = 512;

	// Fixed field widths.
	localparam int REQ_W = 16;
	localparam int DUR_W = 16;
	localparam int AVG_W = 26;

	// Widths that follow from the capacity.
	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam longint unsigned DUR_MAX = (longint'(1) << DUR_W) - 1;
	localparam longint unsigned REQ_MAX = (longint'(1) << REQ_W) - 1;
	localparam longint unsigned TIME_MAX = REQ_MAX + longint'(MAX_JOBS) * DUR_MAX;
	localparam longint unsigned SUM_MAX = longint'(MAX_JOBS) * TIME_MAX;
	localparam int TIME_W = $clog2(TIME_MAX + 1);
	localparam int SUM_W = $clog2(SUM_MAX + 1);
	localparam int QUO_W = (SUM_W > AVG_W) ? SUM_W : AVG_W;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);
	localparam longint unsigned AVG_MAX = (longint'(1) << AVG_W) - 1;

	typedef logic [REQ_W-1:0] req_t;
	typedef logic [DUR_W-1:0] dur_t;
	typedef logic [AVG_W-1:0] avg_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SUM_W-1:0] sum_t;

	// One stored job.
	typedef struct packed {
		logic done;
		req_t req;
		dur_t dur;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic sched_init;
		logic scan_init;
		logic scan_step;
		logic decide;
		logic div_load;
		logic div_step;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic last_pick;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/sjfat_job_if.sv
interface sjfat_job_if;
	logic valid;
	logic ready;
	sjfat_pkg::req_t request_time;
	sjfat_pkg::dur_t duration;
	logic last;

	modport source (output valid, request_time, duration, last, input ready);
	modport sink (input valid, request_time, duration, last, output ready);
endinterface

>>> rtl/sjfat_result_if.sv
interface sjfat_result_if;
	logic valid;
	logic ready;
	sjfat_pkg::avg_t average_turnaround;
	logic overflow;

	modport source (output valid, average_turnaround, overflow, input ready);
	modport sink (input valid, average_turnaround, overflow, output ready);
endinterface

>>> rtl/sjf_average_turnaround_unit.sv
// Channel  Direction  Payload
// job      in         request_time[15:0], duration[15:0], last
// result   out        average_turnaround[25:0], overflow
//
// Jobs are taken one per cycle into a 512-entry store until the job marked last.
// Each decision sweeps the store, then decides; n jobs need n to 2*n decisions,
// then a restoring division runs and the result is registered.
// The single read port of the store sets the sweep length.
// The result waits in an output register; a new set loads while it waits.
// Reset clears the control state and the datapath counters, not the store; the store needs no clearing pass.
module sjf_average_turnaround_unit (
	input  logic          clk,
	input  logic          arst_n,
	sjfat_job_if.sink     job,
	sjfat_result_if.source result
);

	sjfat_pkg::cmd_t cmd;
	sjfat_pkg::sts_t sts;

	sjfat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (job.valid),
		.in_last  (job.last),
		.in_ready (job.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sjfat_dpath u_dpath (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.in_request_time        (job.request_time),
		.in_duration            (job.duration),
		.out_valid              (result.valid),
		.out_ready              (result.ready),
		.out_average_turnaround (result.average_turnaround),
		.out_overflow           (result.overflow)
	);

endmodule

>>> rtl/sjfat_ram.sv
module sjfat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/sjfat_ctrl.sv
module sjfat_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  sjfat_pkg::sts_t  sts,
	output sjfat_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_LOAD     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_DECIDE   = 6'b000100,
		ST_DIV_LOAD = 6'b001000,
		ST_DIVIDE   = 6'b010000,
		ST_EMIT     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;

	// Commands decoded from the state and the status.
	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.sched_init = accept && in_last;
		cmd.scan_init  = (accept && in_last) || ((state_q == ST_DECIDE) && !sts.last_pick);
		cmd.scan_step  = (state_q == ST_SCAN) && !sts.scan_done;
		cmd.decide     = (state_q == ST_DECIDE);
		cmd.div_load   = (state_q == ST_DIV_LOAD);
		cmd.div_step   = (state_q == ST_DIVIDE) && !sts.div_done;
		cmd.emit       = (state_q == ST_EMIT) && sts.out_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && in_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = sts.last_pick ? ST_DIV_LOAD : ST_SCAN;
			end
			ST_DIV_LOAD: begin
				state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/sjfat_dpath.sv
module sjfat_dpath (
	input  logic             clk,
	input  logic             arst_n,
	input  sjfat_pkg::cmd_t  cmd,
	output sjfat_pkg::sts_t  sts,
	input  sjfat_pkg::req_t  in_request_time,
	input  sjfat_pkg::dur_t  in_duration,
	output logic             out_valid,
	input  logic             out_ready,
	output sjfat_pkg::avg_t  out_average_turnaround,
	output logic             out_overflow
);

	// Job store bookkeeping.
	sjfat_pkg::cnt_t   count_q;
	logic              ovf_seen_q;
	logic              full;

	// Scan state.
	sjfat_pkg::cnt_t   scan_addr_q;
	logic              scan_issue;
	logic              rd_valid_s1;
	sjfat_pkg::idx_t   rd_idx_s1;
	sjfat_pkg::entry_t rd_entry;
	logic              found_q;
	sjfat_pkg::idx_t   pick_idx_q;
	sjfat_pkg::req_t   pick_req_q;
	sjfat_pkg::dur_t   pick_dur_q;
	sjfat_pkg::req_t   earliest_q;
	logic              eligible;
	logic              better;

	// Schedule state.
	sjfat_pkg::time_t  time_q;
	sjfat_pkg::sum_t   sum_q;
	sjfat_pkg::cnt_t   served_q;
	sjfat_pkg::time_t  finish;
	sjfat_pkg::time_t  turnaround;

	// Divider.
	sjfat_pkg::sum_t                   quo_q;
	logic [sjfat_pkg::CNT_W-1:0]       rem_q;
	logic [sjfat_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic [sjfat_pkg::CNT_W:0]         rem_shift;
	logic                              quo_bit;
	logic [sjfat_pkg::QUO_W-1:0]       quo_wide;
	sjfat_pkg::avg_t                   avg_sat;

	// Memory port signals.
	logic              mem_we;
	sjfat_pkg::idx_t   mem_waddr;
	sjfat_pkg::entry_t mem_wdata;

	// Output register.
	logic              out_valid_q;
	sjfat_pkg::avg_t   avg_q;
	logic              ovf_q;

	assign full = (count_q == sjfat_pkg::CNT_W'(sjfat_pkg::MAX_JOBS));

	// Write port: new jobs while loading, done marks while scheduling.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[sjfat_pkg::IDX_W-1:0];
		mem_wdata = '{done: 1'b0, req: in_request_time, dur: in_duration};
		if (cmd.load && !full) begin
			mem_we = 1'b1;
		end else if (cmd.decide && found_q) begin
			mem_we    = 1'b1;
			mem_waddr = pick_idx_q;
			mem_wdata = '{done: 1'b1, req: pick_req_q, dur: pick_dur_q};
		end
	end

	assign scan_issue = cmd.scan_step && (scan_addr_q != count_q);

	sjfat_ram #(
		.WIDTH ($bits(sjfat_pkg::entry_t)),
		.DEPTH (sjfat_pkg::MAX_JOBS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (scan_issue),
		.raddr (scan_addr_q[sjfat_pkg::IDX_W-1:0]),
		.rdata (rd_entry)
	);

	// Load count and the overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ovf_seen_q <= 1'b0;
		end else if (cmd.emit) begin
			count_q    <= '0;
			ovf_seen_q <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				ovf_seen_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Candidate compare: shortest duration, then earliest request.
	assign eligible = (sjfat_pkg::TIME_W'(rd_entry.req) <= time_q);
	assign better   = !found_q || (rd_entry.dur < pick_dur_q) ||
	                  ((rd_entry.dur == pick_dur_q) && (rd_entry.req < pick_req_q));

	// Scan address and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else if (cmd.scan_init) begin
			scan_addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			rd_valid_s1 <= scan_issue;
			if (scan_issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			if (rd_valid_s1 && !rd_entry.done && eligible && better) begin
				found_q <= 1'b1;
			end
		end
	end

	// Scan payload: pick and earliest pending request.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_addr_q[sjfat_pkg::IDX_W-1:0];
		if (cmd.scan_init) begin
			earliest_q <= '1;
		end else if (rd_valid_s1 && !rd_entry.done) begin
			if (rd_entry.req < earliest_q) begin
				earliest_q <= rd_entry.req;
			end
			if (eligible && better) begin
				pick_idx_q <= rd_idx_s1;
				pick_req_q <= rd_entry.req;
				pick_dur_q <= rd_entry.dur;
			end
		end
	end

	assign finish     = time_q + sjfat_pkg::TIME_W'(pick_dur_q);
	assign turnaround = finish - sjfat_pkg::TIME_W'(pick_req_q);

	// Clock, turnaround sum and served count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			sum_q    <= '0;
			served_q <= '0;
		end else if (cmd.sched_init) begin
			time_q   <= '0;
			sum_q    <= '0;
			served_q <= '0;
		end else if (cmd.decide) begin
			if (found_q) begin
				time_q   <= finish;
				sum_q    <= sum_q + sjfat_pkg::SUM_W'(turnaround);
				served_q <= served_q + 1'b1;
			end else begin
				time_q <= sjfat_pkg::TIME_W'(earliest_q);
			end
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign rem_shift = {rem_q, quo_q[sjfat_pkg::SUM_W-1]};
	assign quo_bit   = (rem_shift >= {1'b0, count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_load) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[sjfat_pkg::SUM_W-2:0], quo_bit};
			if (quo_bit) begin
				rem_q <= rem_shift[sjfat_pkg::CNT_W-1:0] - count_q;
			end else begin
				rem_q <= rem_shift[sjfat_pkg::CNT_W-1:0];
			end
		end
	end

	// Saturate the mean to the output width.
	assign quo_wide = sjfat_pkg::QUO_W'(quo_q);
	assign avg_sat  = (quo_wide > sjfat_pkg::QUO_W'(sjfat_pkg::AVG_MAX)) ?
	                  '1 : quo_wide[sjfat_pkg::AVG_W-1:0];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			avg_q <= avg_sat;
			ovf_q <= ovf_seen_q;
		end
	end

	assign out_valid              = out_valid_q;
	assign out_average_turnaround = avg_q;
	assign out_overflow           = ovf_q;

	assign sts.scan_done = (scan_addr_q == count_q) && !rd_valid_s1;
	assign sts.last_pick = found_q && ((served_q + 1'b1) == count_q);
	assign sts.div_done  = (div_cnt_q == sjfat_pkg::DIV_CNT_W'(sjfat_pkg::SUM_W));
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule
